### hw/rtl/acts_pkg.sv
// ----------------------------------------------------------------------------
// acts_pkg
// Shared types and constants for the axis calibrate / trimmed smoothing block.
// ----------------------------------------------------------------------------
package acts_pkg;

    localparam int SMP_W            = 16;   // sample and result width
    localparam int OFF_W            = 17;   // offset, half-LSB units
    localparam int SCL_W            = 16;   // scale, Q4.12
    localparam int NUM_AXES         = 3;
    localparam int WINDOW_DEPTH_DEF = 10;
    localparam int CAL_SHIFT        = 13;   // /8192: Q12 scale plus half-LSB offset
    localparam int APB_ADDR_W       = 5;
    localparam int APB_DATA_W       = 32;
    localparam int TRIM_MIN_STEPS   = 2;    // trimming needs more entries than this

    localparam logic [SCL_W-1:0] SCALE_ONE = 16'd4096;

    typedef logic signed [SMP_W-1:0] smp_t;

    // One window entry: index 0 is X, 1 is Y, 2 is Z
    typedef smp_t [NUM_AXES-1:0] tri_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] raw_x;
        logic signed [SMP_W-1:0] raw_y;
        logic signed [SMP_W-1:0] raw_z;
    } in_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] out_x;
        logic signed [SMP_W-1:0] out_y;
        logic signed [SMP_W-1:0] out_z;
    } out_t;

    // Window memory control
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } win_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CAL,
        ST_OLD,
        ST_SCAN,
        ST_DIV,
        ST_WAIT,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        REG_STEPS   = 3'd0,
        REG_TRIM    = 3'd1,
        REG_OFF_X   = 3'd2,
        REG_OFF_Y   = 3'd3,
        REG_OFF_Z   = 3'd4,
        REG_SCALE_X = 3'd5,
        REG_SCALE_Y = 3'd6,
        REG_SCALE_Z = 3'd7
    } cfg_idx_t;

endpackage

### hw/rtl/acts_calib.sv
// ----------------------------------------------------------------------------
// acts_calib
// One-axis calibration: (2*raw - offset) * scale / 8192, truncated, sat16.
// Three register stages; valid is start delayed through v1, v2 and v3 alongside them.
// ----------------------------------------------------------------------------
module acts_calib
    import acts_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  smp_t                    raw,
    input  logic signed [OFF_W-1:0] offset,
    input  logic [SCL_W-1:0]        scale,
    output logic                    valid,
    output smp_t                    cal
);

    localparam int D_W = OFF_W + 1;
    localparam int P_W = D_W + SCL_W + 1;
    localparam int Q_W = P_W - CAL_SHIFT;

    localparam logic signed [P_W-1:0] BIAS = P_W'((1 << CAL_SHIFT) - 1);
    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(32767);
    localparam logic signed [Q_W-1:0] Q_MIN = -Q_W'(32768);

    logic                  v1_reg, v2_reg, v3_reg;
    logic signed [D_W-1:0] d_reg, d_next;
    logic signed [P_W-1:0] prod_reg, prod_next;
    smp_t                  cal_reg, cal_next;
    logic signed [P_W-1:0] biased;
    logic signed [Q_W-1:0] quo;

    always_comb
    begin
        d_next    = {raw[SMP_W-1], raw, 1'b0} - {offset[OFF_W-1], offset};
        prod_next = d_reg * $signed({1'b0, scale});
        // truncate toward zero: bias negatives before the arithmetic shift
        biased    = prod_reg + (prod_reg[P_W-1] ? BIAS : '0);
        quo       = biased[P_W-1:CAL_SHIFT];
        if (quo > Q_MAX)
        begin
            cal_next = smp_t'(Q_MAX);
        end
        else if (quo < Q_MIN)
        begin
            cal_next = smp_t'(Q_MIN);
        end
        else
        begin
            cal_next = quo[SMP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            d_reg <= d_next;
        end
        if (v1_reg)
        begin
            prod_reg <= prod_next;
        end
        if (v2_reg)
        begin
            cal_reg <= cal_next;
        end
    end

    assign valid = v3_reg;
    assign cal   = cal_reg;

endmodule

### hw/rtl/acts_window.sv
// ----------------------------------------------------------------------------
// acts_window
// Window ring store: one write port, one registered read port.
// Per-entry valid bits make unwritten or cleared entries read as zero.
// ----------------------------------------------------------------------------
module acts_window
    import acts_pkg::*;
#(
    parameter int DEPTH = WINDOW_DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  win_ctl_t      ctl,
    input  logic [AW-1:0] rd_addr,
    input  logic [AW-1:0] wr_addr,
    input  tri_t          wr_data,
    output tri_t          rd_data
);

    tri_t             win_mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    tri_t             rd_q_reg;
    logic             rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            win_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_q_reg <= win_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clear)
            begin
                valid_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_hit_reg ? rd_q_reg : '0;

endmodule

### hw/rtl/acts_div.sv
// ----------------------------------------------------------------------------
// acts_div
// Signed by unsigned truncating divider, two quotient bits per cycle.
// done pulses in the cycle after the last step; quo holds until next start.
// ----------------------------------------------------------------------------
module acts_div
    import acts_pkg::*;
#(
    parameter int NUM_W = 20,
    parameter int DEN_W = 4
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic [DEN_W-1:0]        den,
    output logic                    done,
    output logic signed [NUM_W-1:0] quo
);

    localparam int DIV_W = NUM_W + (NUM_W % 2);
    localparam int STEPS = DIV_W / 2;
    localparam int CW    = $clog2(STEPS + 1);

    logic             busy_reg;
    logic             done_reg;
    logic             neg_reg;
    logic [CW-1:0]    cnt_reg;
    logic [DIV_W-1:0] dvd_reg, dvd_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] mag;
    logic [NUM_W-1:0] q_mag;

    assign mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

    // restoring step, two bits
    always_comb
    begin
        logic [DEN_W:0]   r;
        logic [DIV_W-1:0] dv;
        r  = {1'b0, rem_reg};
        dv = dvd_reg;
        for (int k = 0; k < 2; k++)
        begin
            r  = {r[DEN_W-1:0], dv[DIV_W-1]};
            dv = {dv[DIV_W-2:0], 1'b0};
            if (r >= {1'b0, den_reg})
            begin
                r     = r - {1'b0, den_reg};
                dv[0] = 1'b1;
            end
        end
        rem_next = r[DEN_W-1:0];
        dvd_next = dv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= DIV_W'(mag);
            rem_reg <= '0;
            den_reg <= den;
            neg_reg <= num[NUM_W-1];
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign q_mag = dvd_reg[NUM_W-1:0];
    assign quo   = neg_reg ? $signed(-q_mag) : $signed(q_mag);
    assign done  = done_reg;

endmodule

### hw/rtl/axis_calibrate_trimmed_smooth.sv
// ----------------------------------------------------------------------------
// axis_calibrate_trimmed_smooth
// Three-axis magnetometer calibration with moving-average / trimmed smoothing.
// ----------------------------------------------------------------------------
// Each request carries one raw X/Y/Z sample. Per axis the block computes
// (2*raw - offset_half) * scale_q12 / 8192, truncated toward zero and
// saturated to int16. With smooth_steps at 0 that calibrated triple is the
// result. Otherwise it goes into a ring of min(smooth_steps, WINDOW_DEPTH)
// entries held in a single-port-read window memory, per-axis running sums are
// updated by read-modify-write of the oldest slot, and the result is the
// truncating mean; in trimmed mode with more than two steps the first largest
// and first smallest entry are dropped and the rest divided by steps-2.
// Warm-up entries count as zero. Writing smooth_steps clears the history.
// One request is in work at a time; a finished result waits in an output
// register, so the next request is taken while it is still stalled.
// From acceptance the request waits in ST_CAL for the calib register stages;
// with smoothing off it then goes to ST_DONE and the output register. With
// smoothing it passes ST_OLD, ST_DIV and ST_WAIT on the radix-4 divider before
// ST_DONE; trimmed mode adds ST_SCAN after ST_OLD for the window min/max scan,
// one memory read per cycle. The next request is taken in the cycle after the
// result is loaded. Configuration is written over the APB port, register i at
// byte address 4*i, and must only be written while idle.
// ----------------------------------------------------------------------------
module axis_calibrate_trimmed_smooth
    import acts_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // APB configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // sample request channel
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  in_t                   sample,
    // result request channel
    output logic                  result_valid,
    input  logic                  result_stall,
    output out_t                  result
);

    localparam int AW    = $clog2(WINDOW_DEPTH);
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = SMP_W + $clog2(WINDOW_DEPTH);
    localparam int EXT_W = SUM_W - SMP_W;

    // ---------------- configuration registers ----------------
    logic [3:0]              smooth_steps_reg;
    logic                    smooth_trimmed_reg;
    logic signed [OFF_W-1:0] offset_x_reg, offset_y_reg, offset_z_reg;
    logic [SCL_W-1:0]        scale_x_reg, scale_y_reg, scale_z_reg;

    logic     cfg_wr;
    cfg_idx_t cfg_idx;
    logic     steps_wr;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign cfg_idx  = cfg_idx_t'(paddr[4:2]);
    assign steps_wr = cfg_wr && (cfg_idx == REG_STEPS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_steps_reg   <= '0;
            smooth_trimmed_reg <= 1'b0;
            offset_x_reg       <= '0;
            offset_y_reg       <= '0;
            offset_z_reg       <= '0;
            scale_x_reg        <= SCALE_ONE;
            scale_y_reg        <= SCALE_ONE;
            scale_z_reg        <= SCALE_ONE;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_STEPS:   smooth_steps_reg   <= pwdata[3:0];
                REG_TRIM:    smooth_trimmed_reg <= pwdata[0];
                REG_OFF_X:   offset_x_reg       <= pwdata[OFF_W-1:0];
                REG_OFF_Y:   offset_y_reg       <= pwdata[OFF_W-1:0];
                REG_OFF_Z:   offset_z_reg       <= pwdata[OFF_W-1:0];
                REG_SCALE_X: scale_x_reg        <= pwdata[SCL_W-1:0];
                REG_SCALE_Y: scale_y_reg        <= pwdata[SCL_W-1:0];
                REG_SCALE_Z: scale_z_reg        <= pwdata[SCL_W-1:0];
            endcase
        end
    end

    // readback; offsets sign-extended
    always_comb
    begin
        unique case (cfg_idx)
            REG_STEPS:   prdata = APB_DATA_W'(smooth_steps_reg);
            REG_TRIM:    prdata = APB_DATA_W'(smooth_trimmed_reg);
            REG_OFF_X:   prdata = APB_DATA_W'(offset_x_reg);
            REG_OFF_Y:   prdata = APB_DATA_W'(offset_y_reg);
            REG_OFF_Z:   prdata = APB_DATA_W'(offset_z_reg);
            REG_SCALE_X: prdata = APB_DATA_W'(scale_x_reg);
            REG_SCALE_Y: prdata = APB_DATA_W'(scale_y_reg);
            REG_SCALE_Z: prdata = APB_DATA_W'(scale_z_reg);
        endcase
    end

    // ---------------- effective window length ----------------
    logic [CNT_W-1:0] steps_eff;
    logic [CNT_W-1:0] wp_reg;
    logic [CNT_W-1:0] pos_cur;
    logic             trim_use;

    // steps above depth act as depth
    assign steps_eff = (32'(smooth_steps_reg) > WINDOW_DEPTH) ? CNT_W'(WINDOW_DEPTH)
                                                              : CNT_W'(smooth_steps_reg);
    // position past the window wraps before the write
    assign pos_cur   = (wp_reg >= steps_eff) ? '0 : wp_reg;
    assign trim_use  = smooth_trimmed_reg && (32'(steps_eff) > TRIM_MIN_STEPS);

    // ---------------- calibration ----------------
    logic                    cal_start;
    logic [NUM_AXES-1:0]     cal_valid;
    tri_t                    cal_vec;
    tri_t                    raw_vec;
    logic signed [OFF_W-1:0] off_vec [NUM_AXES];
    logic [SCL_W-1:0]        scl_vec [NUM_AXES];

    assign raw_vec[0] = sample.raw_x;
    assign raw_vec[1] = sample.raw_y;
    assign raw_vec[2] = sample.raw_z;
    assign off_vec[0] = offset_x_reg;
    assign off_vec[1] = offset_y_reg;
    assign off_vec[2] = offset_z_reg;
    assign scl_vec[0] = scale_x_reg;
    assign scl_vec[1] = scale_y_reg;
    assign scl_vec[2] = scale_z_reg;

    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_cal
        acts_calib u_calib (
            .clk    (clk),
            .rst_n  (rst_n),
            .start  (cal_start),
            .raw    (raw_vec[a]),
            .offset (off_vec[a]),
            .scale  (scl_vec[a]),
            .valid  (cal_valid[a]),
            .cal    (cal_vec[a])
        );
    end

    // ---------------- window memory ----------------
    win_ctl_t      win_ctl;
    logic [AW-1:0] win_rd_addr;
    logic [AW-1:0] win_wr_addr;
    tri_t          win_rd_data;

    acts_window #(
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (win_ctl),
        .rd_addr (win_rd_addr),
        .wr_addr (win_wr_addr),
        .wr_data (cal_vec),
        .rd_data (win_rd_data)
    );

    // ---------------- sequencer state ----------------
    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        pos_reg;
    logic [CNT_W-1:0]        issue_reg;
    logic [CNT_W-1:0]        cmp_reg;
    logic                    dv_reg;
    logic                    use_trim_reg;
    logic signed [SUM_W-1:0] sum_reg [NUM_AXES];
    smp_t                    hi_reg  [NUM_AXES];
    smp_t                    lo_reg  [NUM_AXES];
    tri_t                    res_reg;
    logic                    result_valid_reg;
    out_t                    result_reg;
    logic                    scan_rd;
    logic                    out_free;
    logic                    scan_last;

    // ---------------- divider ----------------
    logic                    div_start;
    logic [NUM_AXES-1:0]     div_done;
    logic signed [SUM_W-1:0] div_num [NUM_AXES];
    logic signed [SUM_W-1:0] div_quo [NUM_AXES];
    logic [CNT_W-1:0]        div_den;

    assign div_den = use_trim_reg ? steps_eff - CNT_W'(TRIM_MIN_STEPS) : steps_eff;

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            if (use_trim_reg)
            begin
                div_num[a] = sum_reg[a] - {{EXT_W{hi_reg[a][SMP_W-1]}}, hi_reg[a]}
                                        - {{EXT_W{lo_reg[a][SMP_W-1]}}, lo_reg[a]};
            end
            else
            begin
                div_num[a] = sum_reg[a];
            end
        end
    end

    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_div
        acts_div #(
            .NUM_W (SUM_W),
            .DEN_W (CNT_W)
        ) u_div (
            .clk   (clk),
            .rst_n (rst_n),
            .start (div_start),
            .num   (div_num[a]),
            .den   (div_den),
            .done  (div_done[a]),
            .quo   (div_quo[a])
        );
    end

    // ---------------- FSM ----------------
    assign scan_rd   = (state_reg == ST_SCAN) && (issue_reg < steps_eff);
    assign scan_last = dv_reg && (cmp_reg == steps_eff - 1'b1);
    assign out_free  = !result_valid_reg || !result_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    state_next = ST_CAL;
                end
            end
            ST_CAL:
            begin
                if (cal_valid[0])
                begin
                    state_next = (steps_eff == '0) ? ST_DONE : ST_OLD;
                end
            end
            ST_OLD:  state_next = trim_use ? ST_SCAN : ST_DIV;
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:  state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (div_done[0])
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        sample_stall  = (state_reg != ST_IDLE);
        cal_start     = (state_reg == ST_IDLE) && sample_valid;
        // oldest slot read as soon as the calibrated value is ready
        win_ctl.rd_en = ((state_reg == ST_CAL) && cal_valid[0] && (steps_eff != '0))
                        || scan_rd;
        win_ctl.wr_en = (state_reg == ST_OLD);
        win_ctl.clear = steps_wr;
        win_rd_addr   = (state_reg == ST_SCAN) ? issue_reg[AW-1:0] : pos_cur[AW-1:0];
        win_wr_addr   = pos_reg[AW-1:0];
        div_start     = (state_reg == ST_DIV);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            wp_reg           <= '0;
            dv_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                sum_reg[a] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            dv_reg    <= scan_rd;
            if (steps_wr)
            begin
                wp_reg <= '0;
                for (int a = 0; a < NUM_AXES; a++)
                begin
                    sum_reg[a] <= '0;
                end
            end
            else if (state_reg == ST_OLD)
            begin
                // read-modify-write: drop the evicted entry, add the new one
                wp_reg <= pos_reg + 1'b1;
                for (int a = 0; a < NUM_AXES; a++)
                begin
                    sum_reg[a] <= sum_reg[a]
                                  - {{EXT_W{win_rd_data[a][SMP_W-1]}}, win_rd_data[a]}
                                  + {{EXT_W{cal_vec[a][SMP_W-1]}}, cal_vec[a]};
                end
            end
            if ((state_reg == ST_DONE) && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_CAL) && cal_valid[0])
        begin
            pos_reg   <= pos_cur;
            issue_reg <= '0;
            cmp_reg   <= '0;
            res_reg   <= cal_vec;
        end
        if (state_reg == ST_OLD)
        begin
            use_trim_reg <= trim_use;
        end
        if (scan_rd)
        begin
            issue_reg <= issue_reg + 1'b1;
        end
        // window scan: strict compares keep the first max and first min
        if ((state_reg == ST_SCAN) && dv_reg)
        begin
            cmp_reg <= cmp_reg + 1'b1;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                if (cmp_reg == '0)
                begin
                    hi_reg[a] <= win_rd_data[a];
                    lo_reg[a] <= win_rd_data[a];
                end
                else
                begin
                    if ($signed(win_rd_data[a]) > hi_reg[a])
                    begin
                        hi_reg[a] <= win_rd_data[a];
                    end
                    if ($signed(win_rd_data[a]) < lo_reg[a])
                    begin
                        lo_reg[a] <= win_rd_data[a];
                    end
                end
            end
        end
        if ((state_reg == ST_WAIT) && div_done[0])
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                res_reg[a] <= div_quo[a][SMP_W-1:0];
            end
        end
        if ((state_reg == ST_DONE) && out_free)
        begin
            result_reg.out_x <= res_reg[0];
            result_reg.out_y <= res_reg[1];
            result_reg.out_z <= res_reg[2];
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
